### hw/rtl/mbpm_pkg.sv
// ----------------------------------------------------------------------------
// mbpm_pkg
// Shared types and constants for the masked bit pattern matcher.
// ----------------------------------------------------------------------------
package mbpm_pkg;

	localparam int WORD_BITS  = 32;
	localparam int WORD_SHIFT = 5;   // log2 of WORD_BITS
	localparam int KIND_W     = 2;
	localparam int FLEN_W     = 6;
	localparam int TALLY_W    = 12;
	localparam int POP_W      = 6;   // 0..32 ones in one word

	typedef enum logic [KIND_W-1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_DATA   = 2'd2
	} kind_t;

	// Pattern store command, issued on an accepted clear or append transaction
	typedef struct packed {
		logic                 clear;
		logic                 append;
		logic [WORD_BITS-1:0] bits;
		logic [WORD_BITS-1:0] care;
		logic [FLEN_W-1:0]    len;
	} store_cmd_t;

	// One stored word: pattern bits and care mask
	typedef struct packed {
		logic [WORD_BITS-1:0] pattern;
		logic [WORD_BITS-1:0] care;
	} word_t;

endpackage

### hw/rtl/mbpm_cmd_if.sv
// ----------------------------------------------------------------------------
// mbpm_cmd_if / mbpm_res_if
// Valid/ready channels for matcher commands and frame results.
// ----------------------------------------------------------------------------
interface mbpm_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [mbpm_pkg::KIND_W-1:0]    kind;
	logic [mbpm_pkg::WORD_BITS-1:0] field_bits;
	logic [mbpm_pkg::WORD_BITS-1:0] field_care;
	logic [mbpm_pkg::FLEN_W-1:0]    field_length;
	logic [mbpm_pkg::WORD_BITS-1:0] data_word;
	logic                           frame_last;

	modport source (
		output valid, kind, field_bits, field_care, field_length, data_word, frame_last,
		input  ready
	);
	modport sink (
		input  valid, kind, field_bits, field_care, field_length, data_word, frame_last,
		output ready
	);
endinterface

interface mbpm_res_if;
	logic                         valid;
	logic                         ready;
	logic                         matched;
	logic [mbpm_pkg::TALLY_W-1:0] matching_bits;
	logic                         pattern_overflow;

	modport source (
		output valid, matched, matching_bits, pattern_overflow,
		input  ready
	);
	modport sink (
		input  valid, matched, matching_bits, pattern_overflow,
		output ready
	);
endinterface

### hw/rtl/masked_bit_pattern_matcher.sv
// ----------------------------------------------------------------------------
// masked_bit_pattern_matcher
// Compares frame words against a stored masked pattern and counts agreeing bits.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while cmd.ready is high. Clear
// and append transactions update the pattern store in the cycle they are
// accepted; data words flow through a three-stage pipeline (store read,
// compare/popcount, accumulate), whose last stage loads a frame's result into
// the output register with its last word. The output register decouples the
// sides: cmd.ready drops only while a frame's last word sits in the accumulate
// stage and the previous result has not yet been taken. Each data word inside
// the pattern costs one read of the memory's single read port; the partially
// filled final pattern word is held in a register, so appends never read the
// memory and need no forwarding. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module masked_bit_pattern_matcher #(
	parameter int MAX_WORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	mbpm_cmd_if.sink    cmd,
	mbpm_res_if.source  res
);

	localparam int WB    = mbpm_pkg::WORD_BITS;
	localparam int WS    = mbpm_pkg::WORD_SHIFT;
	localparam int TW    = mbpm_pkg::TALLY_W;
	localparam int PW    = mbpm_pkg::POP_W;
	localparam int LEN_W = $clog2(MAX_WORDS * WB + 1);
	localparam int AW    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int FW    = $clog2(MAX_WORDS + 1);
	localparam int CW    = LEN_W + 1;   // compare width

	// Handshake and stall
	logic accept;
	logic is_data;
	logic stall;

	// Store interface
	mbpm_pkg::store_cmd_t scmd;
	logic [LEN_W-1:0]     len;
	logic                 overflow;
	mbpm_pkg::word_t      rd_word;
	logic                 rd_en;
	logic                 rd_tail;

	// Frame position (accept stage)
	logic [FW-1:0] fwi_q;
	logic [FW-1:0] fwi_next;
	logic [CW-1:0] nwords;
	logic          in_pattern;
	logic          covered;

	// Stage 1: memory read in flight
	logic          v_s1;
	logic          cmp_s1;
	logic          last_s1;
	logic          covered_s1;
	logic          ovf_s1;
	logic [WB-1:0] dword_s1;

	// Stage 2: compare result
	logic          v_s2;
	logic          cmp_s2;
	logic          last_s2;
	logic          covered_s2;
	logic          ovf_s2;
	logic          dis_s2;
	logic [PW-1:0] pop_s2;

	logic [WB-1:0] diff;

	// Frame accumulators
	logic          agree_q;
	logic [TW-1:0] tally_q;
	logic          agree_next;
	logic [TW-1:0] tally_next;

	// Output register
	logic          res_valid_q;
	logic          matched_q;
	logic [TW-1:0] bits_q;
	logic          ovf_q;

	// Stall only when a final word must load a still-occupied output register
	assign stall     = v_s2 && last_s2 && res_valid_q && !res.ready;
	assign cmd.ready = !stall;
	assign accept    = cmd.valid && cmd.ready;
	assign is_data   = cmd.kind == mbpm_pkg::KIND_DATA;

	always_comb begin
		scmd.clear  = accept && (cmd.kind == mbpm_pkg::KIND_CLEAR);
		scmd.append = accept && (cmd.kind == mbpm_pkg::KIND_APPEND);
		scmd.bits   = cmd.field_bits;
		scmd.care   = cmd.field_care;
		scmd.len    = cmd.field_length;
	end

	// Words the pattern occupies, rounded up
	assign nwords     = (CW'(len) + CW'(WB - 1)) >> WS;
	assign in_pattern = CW'(fwi_q) < nwords;
	// The word at the current fill point is partial and sits in the tail register
	assign rd_tail    = CW'(fwi_q) == (CW'(len) >> WS);
	assign rd_en      = accept && is_data && in_pattern;
	assign fwi_next   = (fwi_q < FW'(MAX_WORDS)) ? fwi_q + FW'(1) : fwi_q;
	assign covered    = CW'(fwi_next) >= nwords;

	mbpm_store #(
		.MAX_WORDS (MAX_WORDS),
		.LEN_W     (LEN_W),
		.AW        (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (scmd),
		.rd_en    (rd_en),
		.rd_addr  (fwi_q[AW-1:0]),
		.rd_tail  (rd_tail),
		.len      (len),
		.overflow (overflow),
		.rd_word  (rd_word)
	);

	// Frame position tracks accepted data transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwi_q <= '0;
		end else if (accept && is_data) begin
			fwi_q <= cmd.frame_last ? '0 : fwi_next;
		end
	end

	// Pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (!stall) begin
			v_s1 <= accept && is_data;
			v_s2 <= v_s1;
		end
	end

	// Stage 1 payload, captured with the memory read
	always_ff @(posedge clk) begin
		if (!stall) begin
			cmp_s1     <= in_pattern;
			last_s1    <= cmd.frame_last;
			covered_s1 <= covered;
			ovf_s1     <= overflow;
			dword_s1   <= cmd.data_word;
		end
	end

	assign diff = (dword_s1 ^ rd_word.pattern) & rd_word.care;

	// Stage 2: masked compare and popcount
	always_ff @(posedge clk) begin
		if (!stall) begin
			cmp_s2     <= cmp_s1;
			last_s2    <= last_s1;
			covered_s2 <= covered_s1;
			ovf_s2     <= ovf_s1;
			dis_s2     <= diff != '0;
			pop_s2     <= PW'($countones(~diff & rd_word.care));
		end
	end

	always_comb begin
		agree_next = agree_q && !(cmp_s2 && dis_s2);
		tally_next = tally_q + (cmp_s2 ? TW'(pop_s2) : TW'(0));
	end

	// Stage 3: accumulate, emit on frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			agree_q <= 1'b1;
			tally_q <= '0;
		end else if (v_s2 && !stall) begin
			if (last_s2) begin
				agree_q <= 1'b1;
				tally_q <= '0;
			end else begin
				agree_q <= agree_next;
				tally_q <= tally_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (v_s2 && last_s2 && !stall) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && last_s2 && !stall) begin
			matched_q <= agree_next && covered_s2;
			bits_q    <= tally_next;
			ovf_q     <= ovf_s2;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.matched          = matched_q;
	assign res.matching_bits    = bits_q;
	assign res.pattern_overflow = ovf_q;

endmodule

### hw/rtl/mbpm_store.sv
// ----------------------------------------------------------------------------
// mbpm_store
// Pattern/care word memory with bit-stream append packing and a tail word.
// ----------------------------------------------------------------------------
module mbpm_store #(
	parameter int MAX_WORDS = 64,
	parameter int LEN_W     = 12,
	parameter int AW        = 6
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mbpm_pkg::store_cmd_t    cmd,
	input  logic                    rd_en,
	input  logic [AW-1:0]           rd_addr,
	input  logic                    rd_tail,
	output logic [LEN_W-1:0]        len,
	output logic                    overflow,
	output mbpm_pkg::word_t         rd_word
);

	localparam int WB = mbpm_pkg::WORD_BITS;
	localparam int FL = mbpm_pkg::FLEN_W;

	// Complete words live in memory; the partially filled last word lives in tail_q.
	mbpm_pkg::word_t mem [MAX_WORDS];
	mbpm_pkg::word_t rdata_s1;
	mbpm_pkg::word_t tail_s1;
	logic            use_tail_s1;

	logic [LEN_W-1:0]  len_q;
	logic              overflow_q;
	mbpm_pkg::word_t   tail_q;

	logic [FL-1:0]       len_eff;
	logic                fits;
	logic [WB-1:0]       keep;
	logic [4:0]          off;
	logic [6:0]          sh;
	logic [2*WB-1:0]     val_p;
	logic [2*WB-1:0]     val_c;
	mbpm_pkg::word_t     merged;
	mbpm_pkg::word_t     spill;
	logic                complete;
	logic                do_append;
	logic                wr_en;
	logic [AW-1:0]       widx;

	always_comb begin
		len_eff   = (cmd.len > FL'(WB)) ? FL'(WB) : cmd.len;
		fits      = ({1'b0, len_q} + (LEN_W+1)'(len_eff)) <= (LEN_W+1)'(MAX_WORDS * WB);
		keep      = (len_eff == FL'(WB)) ? '1 : WB'((33'd1 << len_eff) - 33'd1);
		off       = len_q[4:0];
		sh        = 7'(2 * WB) - 7'(off) - 7'(len_eff);
		val_p     = {{WB{1'b0}}, cmd.bits & keep} << sh;
		val_c     = {{WB{1'b0}}, cmd.care & keep} << sh;
		merged.pattern = tail_q.pattern | val_p[2*WB-1:WB];
		merged.care    = tail_q.care    | val_c[2*WB-1:WB];
		spill.pattern  = val_p[WB-1:0];
		spill.care     = val_c[WB-1:0];
		complete  = (FL'(off) + len_eff) >= FL'(WB);
		do_append = !cmd.clear && cmd.append && (len_eff != '0) && fits;
		wr_en     = do_append && complete;
		widx      = len_q[mbpm_pkg::WORD_SHIFT +: AW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
			tail_q     <= '0;
		end else if (cmd.clear) begin
			len_q      <= '0;
			overflow_q <= 1'b0;
			tail_q     <= '0;
		end else if (cmd.append && len_eff != '0) begin
			if (!fits) begin
				overflow_q <= 1'b1;
			end else begin
				len_q  <= len_q + LEN_W'(len_eff);
				tail_q <= complete ? spill : merged;
			end
		end
	end

	// Single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[widx] <= merged;
		end
		if (rd_en) begin
			rdata_s1    <= mem[rd_addr];
			tail_s1     <= tail_q;
			use_tail_s1 <= rd_tail;
		end
	end

	assign len      = len_q;
	assign overflow = overflow_q;
	assign rd_word  = use_tail_s1 ? tail_s1 : rdata_s1;

endmodule

### hw/rtl/mbpm_checker.sv
// ----------------------------------------------------------------------------
// mbpm_checker
// Port-level checks for the masked bit pattern matcher.
// ----------------------------------------------------------------------------
module mbpm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic [mbpm_pkg::KIND_W-1:0]  cmd_kind,
	input logic                         cmd_frame_last,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_matched,
	input logic [mbpm_pkg::TALLY_W-1:0] res_matching_bits,
	input logic                         res_pattern_overflow
);

	logic       frame_end;
	logic       res_xfer;
	logic [2:0] pending_q;

	assign frame_end = cmd_valid && cmd_ready && cmd_frame_last
		&& (cmd_kind == mbpm_pkg::KIND_DATA);
	assign res_xfer  = res_valid && res_ready;

	// Frames accepted but not yet reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(frame_end) - 3'(res_xfer);
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_matched)
			&& $stable(res_matching_bits) && $stable(res_pattern_overflow))
		else $error("result changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_xfer |-> pending_q != 3'd0)
		else $error("result without a finished frame");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("too many frames in flight");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("input stalled without output backpressure");

endmodule

bind masked_bit_pattern_matcher mbpm_checker u_mbpm_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.cmd_valid            (cmd.valid),
	.cmd_ready            (cmd.ready),
	.cmd_kind             (cmd.kind),
	.cmd_frame_last       (cmd.frame_last),
	.res_valid            (res.valid),
	.res_ready            (res.ready),
	.res_matched          (res.matched),
	.res_matching_bits    (res.matching_bits),
	.res_pattern_overflow (res.pattern_overflow)
);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked bit pattern matcher. Tasks drive clear,
// append and data transactions with random idle gaps; a checker class keeps
// its own copy of the pattern store and frame state and compares every frame
// verdict field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int KIND_W    = mbpm_pkg::KIND_W;
	localparam int WORD_BITS = mbpm_pkg::WORD_BITS;
	localparam int FLEN_W    = mbpm_pkg::FLEN_W;
	localparam int TALLY_W   = mbpm_pkg::TALLY_W;

	localparam int MAX_WORDS    = 64;
	localparam int HOLD_CYCLES  = 120;        // long receiver hold-off
	localparam int DRAIN_LIMIT  = 20000;      // cycles allowed to drain at the end
	localparam int TAIL_CYCLES  = 10;         // extra wait after draining, before the final check
	localparam int ITEM_TARGET  = 550;

	// kind code the block must ignore
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	typedef struct {
		logic [KIND_W-1:0]    kind;
		logic [WORD_BITS-1:0] fbits;
		logic [WORD_BITS-1:0] fcare;
		logic [FLEN_W-1:0]    flen;
		logic [WORD_BITS-1:0] dword;
		logic                 last;
	} cmd_item_t;

	typedef struct packed {
		logic               matched;
		logic [TALLY_W-1:0] tally;
		logic               overflow;
	} verdict_t;

	// ------------------------------------------------------------------------
	// Checker: mirrors the pattern store and frame state, queues the verdict
	// each final data word must produce, and checks what comes out.
	// ------------------------------------------------------------------------
	class match_checker;
		logic [WORD_BITS-1:0] pattern_words[MAX_WORDS];
		logic [WORD_BITS-1:0] care_words[MAX_WORDS];
		logic [11:0]          pattern_len;
		logic [6:0]           frame_pos;
		logic                 frame_agree;
		logic [TALLY_W-1:0]   frame_tally;
		logic                 overflow_seen;
		verdict_t             verdicts_due[$];
		int unsigned          mismatches;

		function new();
			for (int i = 0; i < MAX_WORDS; i++) begin
				pattern_words[i] = '0;
				care_words[i]    = '0;
			end
			pattern_len   = '0;
			frame_pos     = '0;
			frame_agree   = 1'b1;
			frame_tally   = '0;
			overflow_seen = 1'b0;
			mismatches    = 0;
		endfunction

		function int unsigned words_in_use();
			return (pattern_len + 31) / WORD_BITS;
		endfunction

		// pack a field MSB first behind the current pattern tail
		function void append_field(logic [WORD_BITS-1:0] bits, logic [WORD_BITS-1:0] care,
				logic [FLEN_W-1:0] flen);
			int unsigned          n;
			int unsigned          widx;
			int unsigned          off;
			int unsigned          avail;
			int unsigned          rem;
			logic [WORD_BITS-1:0] keep;
			n = (flen > 32) ? 32 : flen;
			if (n == 0)
				return;
			if (pattern_len + n > MAX_WORDS * WORD_BITS) begin
				overflow_seen = 1'b1;
				return;
			end
			keep = (n == 32) ? 32'hffff_ffff : ((32'd1 << n) - 32'd1);
			bits &= keep;
			care &= keep;
			widx  = pattern_len / WORD_BITS;
			off   = pattern_len % WORD_BITS;
			avail = WORD_BITS - off;
			if (off == 0) begin
				pattern_words[widx] = '0;
				care_words[widx]    = '0;
			end
			if (n <= avail) begin
				pattern_words[widx] |= bits << (avail - n);
				care_words[widx]    |= care << (avail - n);
			end else begin
				rem = n - avail;
				pattern_words[widx] |= bits >> rem;
				care_words[widx]    |= care >> rem;
				if (widx + 1 < MAX_WORDS) begin
					pattern_words[widx + 1] = bits << (WORD_BITS - rem);
					care_words[widx + 1]    = care << (WORD_BITS - rem);
				end
			end
			pattern_len += n;
		endfunction

		function void take_command(cmd_item_t it);
			int unsigned          nwords;
			logic [WORD_BITS-1:0] diff;
			verdict_t             v;
			case (it.kind)
				mbpm_pkg::KIND_CLEAR: begin
					pattern_len   = '0;
					overflow_seen = 1'b0;
				end
				mbpm_pkg::KIND_APPEND: append_field(it.fbits, it.fcare, it.flen);
				mbpm_pkg::KIND_DATA: begin
					nwords = words_in_use();
					if (frame_pos < nwords && frame_pos < MAX_WORDS) begin
						diff = (it.dword ^ pattern_words[frame_pos]) & care_words[frame_pos];
						if (diff != '0)
							frame_agree = 1'b0;
						frame_tally += $countones(~diff & care_words[frame_pos]);
					end
					if (frame_pos < MAX_WORDS)
						frame_pos++;
					if (it.last) begin
						v.matched  = frame_agree && (frame_pos >= nwords);
						v.tally    = frame_tally;
						v.overflow = overflow_seen;
						verdicts_due.insert(verdicts_due.size(), v);
						frame_pos   = '0;
						frame_agree = 1'b1;
						frame_tally = '0;
					end
				end
				default: ;    // unused kind, ignored
			endcase
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("[%0t] mismatch: %s", $realtime, msg);
		endtask

		task check_verdict(logic matched, logic [TALLY_W-1:0] tally, logic overflow);
			verdict_t want;
			if (verdicts_due.size() == 0) begin
				report_mismatch("verdict with none pending");
				return;
			end
			want = verdicts_due.pop_front();
			if (matched !== want.matched)
				report_mismatch($sformatf("matched %b, want %b", matched, want.matched));
			if (tally !== want.tally)
				report_mismatch($sformatf("matching_bits %0d, want %0d", tally, want.tally));
			if (overflow !== want.overflow)
				report_mismatch($sformatf("pattern_overflow %b, want %b", overflow,
					want.overflow));
		endtask
	endclass

	logic clk;
	logic arst_n;

	mbpm_cmd_if cmd_ch();
	mbpm_res_if res_ch();

	masked_bit_pattern_matcher #(.MAX_WORDS(MAX_WORDS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	match_checker sb = new();

	bit          no_idle;      // set for stretches where neither side idles
	bit          hold_req;     // asks the receiver for one long hold-off
	int unsigned items_sent;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Everything the block sees is known from time zero
	initial begin
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.kind         = mbpm_pkg::KIND_CLEAR;
		cmd_ch.field_bits   = '0;
		cmd_ch.field_care   = '0;
		cmd_ch.field_length = '0;
		cmd_ch.data_word    = '0;
		cmd_ch.frame_last   = 1'b0;
		res_ch.ready        = 1'b0;
	end

	// Idle gap length: mostly none, often short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 45);
	endfunction

	// Append length, including zero and values past 32 that clamp
	function automatic logic [FLEN_W-1:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 6'd0;
		if (r < 15)
			return FLEN_W'($urandom_range(33, 63));
		if (r < 25)
			return 6'd32;
		return FLEN_W'($urandom_range(1, 31));
	endfunction

	// Transaction of the given kind; fields it does not use carry random junk
	function automatic cmd_item_t mk_item(logic [KIND_W-1:0] kind);
		cmd_item_t it;
		it.kind  = kind;
		it.fbits = $urandom();
		it.fcare = $urandom();
		it.flen  = FLEN_W'($urandom_range(0, 63));
		it.dword = $urandom();
		it.last  = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic cmd_item_t mk_append(logic [WORD_BITS-1:0] bits,
			logic [WORD_BITS-1:0] care, logic [FLEN_W-1:0] flen);
		cmd_item_t it;
		it       = mk_item(mbpm_pkg::KIND_APPEND);
		it.fbits = bits;
		it.fcare = care;
		it.flen  = flen;
		return it;
	endfunction

	function automatic cmd_item_t mk_data(logic [WORD_BITS-1:0] w, logic last);
		cmd_item_t it;
		it       = mk_item(mbpm_pkg::KIND_DATA);
		it.dword = w;
		it.last  = last;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	// valid is written once per step, so back-to-back transactions keep it high.
	task automatic send_item(cmd_item_t it);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.kind         <= it.kind;
		cmd_ch.field_bits   <= it.fbits;
		cmd_ch.field_care   <= it.fcare;
		cmd_ch.field_length <= it.flen;
		cmd_ch.data_word    <= it.dword;
		cmd_ch.frame_last   <= it.last;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		sb.take_command(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Clear, then append fields until the pattern reaches the target length
	// or an append overflows. whole_words keeps every field at 32 bits.
	task automatic load_pattern(int unsigned target, bit whole_words);
		send_item(mk_item(mbpm_pkg::KIND_CLEAR));
		while (sb.pattern_len < target && !sb.overflow_seen)
			send_item(mk_append($urandom(), $urandom(), whole_words ? 6'd32 : pick_len()));
	endtask

	// Frame built from the stored pattern: most words agree exactly, some
	// flip care bits, some flip arbitrary bits; words past the pattern are noise.
	task automatic send_frame(int unsigned n_words);
		int unsigned          r;
		logic [WORD_BITS-1:0] w;
		for (int unsigned i = 0; i < n_words; i++) begin
			if (i < sb.words_in_use()) begin
				w = sb.pattern_words[i];
				r = $urandom_range(0, 99);
				if (r >= 60 && r < 85)
					w ^= $urandom() & sb.care_words[i];
				else if (r >= 85)
					w ^= $urandom() & $urandom();
			end else begin
				w = $urandom();
			end
			send_item(mk_data(w, i == n_words - 1));
		end
	endtask

	// Frame length near the pattern size: one short up to a few long
	task automatic send_near_frame();
		int n;
		n = int'(sb.words_in_use()) + $urandom_range(0, 4) - 1;
		send_frame((n < 1) ? 1 : n);
	endtask

	// Receiver: random ready with stalls; one long hold-off on request while
	// the sender keeps pushing, so the pipeline backs up into cmd.ready.
	initial begin
		int unsigned n;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					res_ch.ready <= 1'b0;
					repeat (n) @(negedge clk);
				end
				res_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
	end

	// Result monitor: every accepted result transaction is checked
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_verdict(res_ch.matched, res_ch.matching_bits, res_ch.pattern_overflow);
	end

	initial begin
		int unsigned r;
		int unsigned drain;
		no_idle    = 1'b0;
		hold_req   = 1'b0;
		items_sent = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed ----
		send_item(mk_data($urandom(), 1'b1));                        // empty pattern
		send_item(mk_item(mbpm_pkg::KIND_CLEAR));
		send_item(mk_append(32'hffff_ffff, 32'hffff_ffff, 6'd0));    // zero length
		send_item(mk_append(32'hffff_ffff, 32'hffff_ffff, 6'd32));   // full word
		send_item(mk_append($urandom(), $urandom(), 6'd63));         // clamps to 32
		send_item(mk_append(32'hffff_ffff, 32'hffff_ffe5, 6'd5));    // junk above length
		send_item(mk_item(KIND_UNUSED));                             // ignored
		send_frame(3);                                               // covers 69 bits
		send_item(mk_data(sb.pattern_words[0], 1'b1));               // frame too short
		send_frame(6);                                               // frame too long
		send_item(mk_data(32'h0000_0000, 1'b0));
		send_item(mk_data(32'hffff_ffff, 1'b1));
		// pattern grows mid frame; later words see the new tail
		send_item(mk_data(sb.pattern_words[0], 1'b0));
		send_item(mk_append($urandom(), 32'hffff_ffff, 6'd12));
		send_item(mk_data(sb.pattern_words[1], 1'b0));
		send_item(mk_data(sb.pattern_words[2], 1'b1));
		// clear mid frame; remaining words compare against an empty pattern
		send_item(mk_data(sb.pattern_words[0], 1'b0));
		send_item(mk_item(mbpm_pkg::KIND_CLEAR));
		send_item(mk_data($urandom(), 1'b1));

		// full store: a 64-word frame, then a frame past the counter limit
		load_pattern(MAX_WORDS * WORD_BITS, 1'b1);
		send_frame(MAX_WORDS);
		send_frame(MAX_WORDS + 6);
		send_item(mk_append($urandom(), $urandom(), 6'd1));          // store full
		send_item(mk_data($urandom(), 1'b1));                        // shows sticky flag
		send_item(mk_item(mbpm_pkg::KIND_CLEAR));                    // clears the flag
		send_item(mk_data($urandom(), 1'b1));

		// ---- back-pressure: long receiver hold while one-word frames keep coming ----
		load_pattern(20, 1'b0);
		no_idle  = 1'b1;
		hold_req = 1'b1;
		repeat (30) send_frame(1);
		no_idle  = 1'b0;

		// ---- random ----
		while (items_sent < ITEM_TARGET) begin
			no_idle = ($urandom_range(0, 9) == 0);
			r = $urandom_range(0, 99);
			if (r < 55) begin
				load_pattern($urandom_range(1, 100), 1'b0);
				repeat ($urandom_range(1, 3)) send_near_frame();
			end else if (r < 70) begin
				repeat ($urandom_range(1, 3)) send_frame($urandom_range(1, 6));
			end else if (r < 80) begin
				// pattern change inside a frame
				send_frame($urandom_range(1, 3));
				if ($urandom_range(0, 1))
					send_item(mk_item(mbpm_pkg::KIND_CLEAR));
				send_item(mk_append($urandom(), $urandom(), pick_len()));
				send_near_frame();
			end else if (r < 96) begin
				repeat ($urandom_range(1, 4)) send_item(mk_item(KIND_W'($urandom_range(0, 3))));
			end else begin
				// large pattern, sometimes past capacity
				load_pattern($urandom_range(1500, 2100), 1'b0);
				send_near_frame();
			end
		end

		no_idle = 1'b0;
		cmd_ch.valid <= 1'b0;

		drain = 0;
		while (sb.verdicts_due.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.verdicts_due.size() != 0)
			sb.report_mismatch($sformatf("%0d verdicts never arrived", sb.verdicts_due.size()));

		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Hard stop, several times the slowest legal run
	initial begin
		#6000000;
		$display("simulation failed");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/mbpm_pkg.sv
hw/rtl/mbpm_cmd_if.sv
hw/rtl/mbpm_store.sv
hw/rtl/masked_bit_pattern_matcher.sv
hw/rtl/mbpm_checker.sv
verif/tb_top.sv
